@@ sv/lrupr_pkg.sv @@
// Shared types, constants and helper functions for the LRU page replacement unit.
// Used by lrupr_lookup and lru_page_replacement_unit. No dependencies.
`default_nettype none

package lrupr_pkg;

   // Default values of the top-level parameters
   localparam int NUM_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   // Largest frame count supported, and the index width it needs
   localparam int MAX_FRAMES     = 32;
   localparam int MAX_FRAME_BITS = 5;

   // Fixed port widths
   localparam int PAGE_ID_W   = 16;
   localparam int FRAME_IDX_W = 3;
   localparam int FAULT_W     = 16;
   localparam int FIU_W       = 4;

   // Reset value of the frames_in_use register
   localparam logic [FIU_W-1:0] FIU_RESET = 4'd8;

   // Saturation point of the fault counter
   localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

   // Index of the lowest set bit; zero when no bit is set
   function automatic logic [MAX_FRAME_BITS-1:0] first_set_index(
      input logic [MAX_FRAMES-1:0] vec
   );
      logic [MAX_FRAMES-1:0]     lone;
      logic [MAX_FRAME_BITS-1:0] idx;
      lone = vec & (~vec + MAX_FRAMES'(1));
      idx  = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         if (lone[i]) begin
            idx = idx | MAX_FRAME_BITS'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

@@ sv/lrupr_lookup.sv @@
// Frame lookup for the LRU page replacement unit: parallel page compare, first
// empty frame search and least-recently-used victim select. Uses lrupr_pkg.
`default_nettype none

module lrupr_lookup #(
   parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
   input  wire logic [PAGE_BITS-1:0]                            page,
   input  wire logic [lrupr_pkg::FIU_W-1:0]                     frames_in_use,
   input  wire logic [NUM_FRAMES-1:0][PAGE_BITS-1:0]            frame_page,
   input  wire logic [NUM_FRAMES-1:0]                           frame_valid,
   input  wire logic [NUM_FRAMES-1:0][$clog2(NUM_FRAMES)-1:0]   frame_rank,
   output logic                                                 hit,
   output logic [NUM_FRAMES-1:0]                                frame_sel,
   output logic [$clog2(NUM_FRAMES)-1:0]                        frame_idx
);

   localparam int FRAME_BITS = $clog2(NUM_FRAMES);
   localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

   logic [CNT_W-1:0]                      act_cnt;
   logic [NUM_FRAMES-1:0]                 active;
   logic [NUM_FRAMES-1:0]                 hit_vec;
   logic [NUM_FRAMES-1:0]                 empty_vec;
   logic [NUM_FRAMES-1:0]                 lru_vec;
   logic [NUM_FRAMES-1:0]                 hit_one;
   logic [NUM_FRAMES-1:0]                 empty_one;
   logic [lrupr_pkg::MAX_FRAME_BITS-1:0]  sel_idx;

   // Clamp frames_in_use into 1..NUM_FRAMES
   always_comb begin
      if (frames_in_use == '0) begin
         act_cnt = CNT_W'(1);
      end else if (32'(frames_in_use) > NUM_FRAMES) begin
         act_cnt = CNT_W'(NUM_FRAMES);
      end else begin
         act_cnt = CNT_W'(frames_in_use);
      end
   end

   // Per-frame match, empty and active flags
   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
         active[i]    = CNT_W'(i) < act_cnt;
         hit_vec[i]   = active[i] && frame_valid[i] && (frame_page[i] == page);
         empty_vec[i] = active[i] && !frame_valid[i];
      end
   end

   // Victim: first active frame holding the largest rank (pairwise compares)
   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
         lru_vec[i] = active[i];
         for (int j = 0; j < NUM_FRAMES; j++) begin
            if (j < i && active[j] && !(frame_rank[j] < frame_rank[i])) begin
               lru_vec[i] = 1'b0;
            end
            if (j > i && active[j] && (frame_rank[j] > frame_rank[i])) begin
               lru_vec[i] = 1'b0;
            end
         end
      end
   end

   // Isolate the lowest set bit of the hit and empty vectors
   assign hit_one   = hit_vec & (~hit_vec + NUM_FRAMES'(1));
   assign empty_one = empty_vec & (~empty_vec + NUM_FRAMES'(1));

   // Pick hit frame, else first empty, else LRU victim
   always_comb begin
      hit = |hit_vec;
      if (hit) begin
         frame_sel = hit_one;
      end else if (|empty_vec) begin
         frame_sel = empty_one;
      end else begin
         frame_sel = lru_vec;
      end
      sel_idx   = lrupr_pkg::first_set_index(lrupr_pkg::MAX_FRAMES'(frame_sel));
      frame_idx = sel_idx[FRAME_BITS-1:0];
   end

endmodule

`default_nettype wire

@@ sv/lru_page_replacement_unit.sv @@
// Top level of the LRU page replacement unit: request register, frame table,
// recency update and response register. Uses lrupr_pkg and lrupr_lookup.
`default_nettype none

// One page reference is taken per cycle while rsp_ready holds; each is answered
// through the request register, then the response register. The lookup and the
// recency update on the frame table are combinational. A response waiting on
// rsp_ready holds the request register, so at most one more request is registered
// behind it. After reset all frames are empty at once, with no clearing pass. The
// user must write frames_in_use (csr_frames_in_use, reset 8) only while idle; the
// block does not enforce it. Zero acts as one and values above NUM_FRAMES act as
// NUM_FRAMES. rsp_frame_index carries the low three bits of the frame number.
module lru_page_replacement_unit #(
   parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [lrupr_pkg::PAGE_ID_W-1:0]     req_page_id,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_hit,
   output logic [lrupr_pkg::FRAME_IDX_W-1:0]        rsp_frame_index,
   output logic [lrupr_pkg::FAULT_W-1:0]            rsp_fault_count,
   // configuration write channel
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lrupr_pkg::FIU_W-1:0]         csr_frames_in_use
);

   localparam int RANK_W = $clog2(NUM_FRAMES);
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_FRAMES - 1);

   // request register
   logic                        in_vld_ff;
   logic                        in_vld_in;
   logic [PAGE_BITS-1:0]        page_ff;
   logic [PAGE_BITS-1:0]        page_in;

   // frame table and counters
   logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] fpage_ff;
   logic [NUM_FRAMES-1:0][PAGE_BITS-1:0] fpage_in;
   logic [NUM_FRAMES-1:0]                valid_ff;
   logic [NUM_FRAMES-1:0]                valid_in;
   logic [NUM_FRAMES-1:0][RANK_W-1:0]    rank_ff;
   logic [NUM_FRAMES-1:0][RANK_W-1:0]    rank_in;
   logic [lrupr_pkg::FAULT_W-1:0]        faults_ff;
   logic [lrupr_pkg::FAULT_W-1:0]        faults_in;
   logic [lrupr_pkg::FIU_W-1:0]          fiu_ff;
   logic [lrupr_pkg::FIU_W-1:0]          fiu_in;

   // response register
   logic                                 rsp_vld_ff;
   logic                                 rsp_vld_in;
   logic                                 rsp_hit_ff;
   logic                                 rsp_hit_in;
   logic [lrupr_pkg::FRAME_IDX_W-1:0]    rsp_idx_ff;
   logic [lrupr_pkg::FRAME_IDX_W-1:0]    rsp_idx_in;
   logic [lrupr_pkg::FAULT_W-1:0]        rsp_cnt_ff;
   logic [lrupr_pkg::FAULT_W-1:0]        rsp_cnt_in;

   // lookup results
   logic                        lk_hit;
   logic [NUM_FRAMES-1:0]       lk_sel;
   logic [RANK_W-1:0]           lk_idx;
   logic                        sel_was_valid;
   logic [RANK_W-1:0]           sel_rank;
   logic                        fire;
   logic [NUM_FRAMES-1:0]       rank0_vec;

   lrupr_lookup #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_lookup (
      .page          (page_ff),
      .frames_in_use (fiu_ff),
      .frame_page    (fpage_ff),
      .frame_valid   (valid_ff),
      .frame_rank    (rank_ff),
      .hit           (lk_hit),
      .frame_sel     (lk_sel),
      .frame_idx     (lk_idx)
   );

   // handshakes
   assign fire      = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;
   assign csr_ready = 1'b1;

   // request register next state
   always_comb begin
      in_vld_in = in_vld_ff;
      page_in   = page_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
         page_in   = PAGE_BITS'(req_page_id);
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   // state of the frame being used
   always_comb begin
      sel_was_valid = |(lk_sel & valid_ff);
      sel_rank      = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (lk_sel[i]) begin
            sel_rank = sel_rank | rank_ff[i];
         end
      end
   end

   // frame table, recency and fault counter update
   always_comb begin
      fpage_in  = fpage_ff;
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      faults_in = faults_ff;
      if (fire) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (lk_sel[i]) begin
               rank_in[i]  = '0;
               valid_in[i] = 1'b1;
               if (!lk_hit) begin
                  fpage_in[i] = page_ff;
               end
            end else if (valid_ff[i] && (!sel_was_valid || rank_ff[i] < sel_rank)
                         && rank_ff[i] < RANK_MAX) begin
               rank_in[i] = rank_ff[i] + RANK_W'(1);
            end
         end
         if (!lk_hit && faults_ff != lrupr_pkg::FAULT_MAX) begin
            faults_in = faults_ff + lrupr_pkg::FAULT_W'(1);
         end
      end
   end

   // configuration register
   always_comb begin
      fiu_in = fiu_ff;
      if (csr_valid && csr_ready) begin
         fiu_in = csr_frames_in_use;
      end
   end

   // response register next state
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_hit_in = rsp_hit_ff;
      rsp_idx_in = rsp_idx_ff;
      rsp_cnt_in = rsp_cnt_ff;
      if (fire) begin
         rsp_vld_in = 1'b1;
         rsp_hit_in = lk_hit;
         rsp_idx_in = lrupr_pkg::FRAME_IDX_W'(lk_idx);
         rsp_cnt_in = faults_in;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         rank_ff    <= '0;
         faults_ff  <= '0;
         fiu_ff     <= lrupr_pkg::FIU_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         valid_ff   <= valid_in;
         rank_ff    <= rank_in;
         faults_ff  <= faults_in;
         fiu_ff     <= fiu_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff    <= page_in;
      fpage_ff   <= fpage_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_index = rsp_idx_ff;
   assign rsp_fault_count = rsp_cnt_ff;

   // valid frames holding rank zero
   always_comb begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
         rank0_vec[i] = valid_ff[i] && (rank_ff[i] == '0);
      end
   end

   // lookup always picks exactly one frame
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |-> $onehot(lk_sel))
      else $error("lookup did not select exactly one frame");

   // the frame used becomes valid and most recent
   a_used_mru: assert property (@(posedge clock) disable iff (reset)
      fire |=> ((valid_ff & $past(lk_sel)) == $past(lk_sel))
               && ((rank0_vec & $past(lk_sel)) == $past(lk_sel)))
      else $error("used frame not marked valid with rank zero");

   // at most one valid frame is most recent
   a_one_mru: assert property (@(posedge clock) disable iff (reset)
      $countones(rank0_vec) <= 1)
      else $error("several valid frames hold rank zero");

   // a hit leaves the fault counter alone
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      fire && lk_hit |=> faults_ff == $past(faults_ff))
      else $error("fault counter moved on a hit");

   // a request waiting in the request register is not dropped
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(page_ff))
      else $error("pending request lost");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for lru_page_replacement_unit: a frame tracker class
// predicts each response; plain tasks drive requests, responses and the CSR.
// Depends on lrupr_pkg and the RTL of lru_page_replacement_unit only.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_FRAMES  = lrupr_pkg::NUM_FRAMES_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_CAP  = 200;
   localparam int LAST_RANK   = NUM_FRAMES - 1;

   typedef struct packed {
      logic                              hit;
      logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index;
      logic [lrupr_pkg::FAULT_W-1:0]     fault_count;
   } page_outcome_type;

   // Tracks the frame table and LRU ranks, queues the expected response per request
   class lru_frame_tracker;
      logic [lrupr_pkg::PAGE_ID_W-1:0] held_page [NUM_FRAMES];
      bit                              held_valid [NUM_FRAMES];
      logic [2:0]                      age_rank [NUM_FRAMES];
      logic [lrupr_pkg::FAULT_W-1:0]   fault_total;
      logic [lrupr_pkg::FIU_W-1:0]     frames_cfg;
      page_outcome_type                outcome_q [$];
      int                              errors;

      function new();
         for (int i = 0; i < NUM_FRAMES; i++) begin
            held_page[i]  = '0;
            held_valid[i] = 1'b0;
            age_rank[i]   = '0;
         end
         fault_total = '0;
         frames_cfg  = lrupr_pkg::FIU_RESET;
         errors      = 0;
      endfunction

      function void write_frames(logic [lrupr_pkg::FIU_W-1:0] value);
         frames_cfg = value;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // One page reference: search, pick a frame on a fault, refresh ranks
      function void note_reference(logic [lrupr_pkg::PAGE_ID_W-1:0] page);
         int               active;
         int               pick;
         bit               found;
         bit               was_valid;
         logic [2:0]       old_rank;
         page_outcome_type outcome;
         active = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : frames_cfg);
         pick   = 0;
         found  = 1'b0;
         for (int i = 0; i < active; i++) begin
            if (!found && held_valid[i] && held_page[i] == page) begin
               found = 1'b1;
               pick  = i;
            end
         end
         outcome.hit = found;
         if (!found) begin
            // lowest empty frame first, else the oldest (lowest index on a tie)
            for (int i = active - 1; i >= 0; i--) begin
               if (!held_valid[i]) begin
                  found = 1'b1;
                  pick  = i;
               end
            end
            if (!found) begin
               pick = 0;
               for (int i = 1; i < active; i++) begin
                  if (age_rank[i] > age_rank[pick]) pick = i;
               end
            end
            held_page[pick] = page;
            if (fault_total != lrupr_pkg::FAULT_MAX) fault_total = fault_total + 1'b1;
         end
         was_valid = held_valid[pick];
         old_rank  = age_rank[pick];
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (i != pick && held_valid[i] && (!was_valid || age_rank[i] < old_rank)) begin
               if (age_rank[i] < LAST_RANK) age_rank[i] = age_rank[i] + 1'b1;
            end
         end
         age_rank[pick]   = '0;
         held_valid[pick] = 1'b1;
         outcome.frame_index = lrupr_pkg::FRAME_IDX_W'(pick);
         outcome.fault_count = fault_total;
         outcome_q.push_back(outcome);
      endfunction

      function void mismatch(string field, int unsigned want, int unsigned got);
         errors++;
         // keep the log readable if something breaks early in the run
         if (errors <= REPORT_CAP) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         end
      endfunction

      function void check_response(logic hit, logic [lrupr_pkg::FRAME_IDX_W-1:0] frame_index,
                                   logic [lrupr_pkg::FAULT_W-1:0] fault_count);
         page_outcome_type want;
         if (outcome_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP) $error("response with no request outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (hit !== want.hit) mismatch("hit", want.hit, hit);
            if (frame_index !== want.frame_index)
               mismatch("frame_index", want.frame_index, frame_index);
            if (fault_count !== want.fault_count)
               mismatch("fault_count", want.fault_count, fault_count);
         end
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [lrupr_pkg::PAGE_ID_W-1:0]   req_page_id;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic                              rsp_hit;
   logic [lrupr_pkg::FRAME_IDX_W-1:0] rsp_frame_index;
   logic [lrupr_pkg::FAULT_W-1:0]     rsp_fault_count;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [lrupr_pkg::FIU_W-1:0]       csr_frames_in_use;

   lru_frame_tracker tracker = new();
   bit               idle_on;
   bit               stall_on;
   int               cycles;

   lru_page_replacement_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_id       (req_page_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Monitor: every handshake is sampled at the edge that completes it
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_frames(csr_frames_in_use);
         if (req_valid && req_ready) tracker.note_reference(req_page_id);
         if (rsp_valid && rsp_ready)
            tracker.check_response(rsp_hit, rsp_frame_index, rsp_fault_count);
      end
   end

   // Response backpressure in random bursts
   initial begin
      rsp_ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Present one page reference and hold it until accepted
   task automatic send_page(input logic [lrupr_pkg::PAGE_ID_W-1:0] page);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_page_id <= page;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop requests and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frames(input logic [lrupr_pkg::FIU_W-1:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Stimulus
   initial begin
      logic [lrupr_pkg::PAGE_ID_W-1:0] pool [16];
      logic [lrupr_pkg::FIU_W-1:0]     frames_plan [10];
      logic [lrupr_pkg::PAGE_ID_W-1:0] page;
      int                              active;
      int                              pool_size;
      int                              pick;
      int                              count;

      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_page_id       <= '0;
      csr_valid         <= 1'b0;
      csr_frames_in_use <= '0;
      idle_on  = 1'b1;
      stall_on = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: fill all eight frames, evict, then shrink and regrow the set
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'h5555);
      send_page(16'hAAAA);
      send_page(16'h00FF);
      send_page(16'hFF00);
      send_page(16'h0F0F);
      send_page(16'hF0F0);
      send_page(16'h1234);
      send_page(16'h5555);
      send_page(16'hFFFF);
      send_page(16'h1234);
      // frames above the active set keep their pages but are not searched
      set_frames(4'd3);
      send_page(16'h0F0F);
      send_page(16'hAAAA);
      // zero acts as one frame
      set_frames(4'd0);
      send_page(16'h7777);
      send_page(16'h7777);
      send_page(16'h8888);
      // above the frame count acts as all frames; retained pages hit again
      set_frames(4'd15);
      send_page(16'h0F0F);
      send_page(16'hF0F0);

      // Random phases: mostly a small working set so hits and evictions mix
      frames_plan = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd12, 4'd2, 4'd9, 4'd4};
      frames_plan[9] = 4'($urandom_range(0, 15));
      for (int k = 0; k < 16; k++) pool[k] = 16'($urandom_range(0, 65535));
      for (int ph = 0; ph < 10; ph++) begin
         set_frames(frames_plan[ph]);
         idle_on  = ($urandom_range(0, 3) != 0);
         stall_on = ($urandom_range(0, 3) != 0);
         active = (frames_plan[ph] == 0) ? 1 :
                  ((frames_plan[ph] > NUM_FRAMES) ? NUM_FRAMES : frames_plan[ph]);
         pool_size = active + $urandom_range(0, active + 2);
         if (pool_size > 16) pool_size = 16;
         repeat ($urandom_range(2, 6)) pool[$urandom_range(0, 15)] = 16'($urandom_range(0, 65535));
         count = $urandom_range(70, 90);
         for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 19);
            if (pick < 17)
               page = pool[$urandom_range(0, pool_size - 1)];
            else if (pick < 19)
               page = 16'($urandom_range(0, 65535));
            else
               page = pool[$urandom_range(0, pool_size - 1)] ^ (16'h1 << $urandom_range(0, 15));
            send_page(page);
         end
      end

      // Last part, no idling: back-to-back distinct pages keep evicting at full rate
      idle_on  = 1'b0;
      stall_on = 1'b0;
      set_frames(4'd8);
      for (int k = 0; k < 150; k++) send_page(16'(k) ^ 16'h3C5A);

      drain();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
